// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/des_pkg.sv =====
// ----------------------------------------------------------------------------
// DES package
// Tables, permutation functions and mode codes for the DES block.
// ----------------------------------------------------------------------------
`default_nettype none
package des_pkg;
  localparam logic [1:0] ModeEcb = 2'd0;
  localparam logic [1:0] ModeCbc = 2'd1;
  localparam logic [1:0] ModeCfb = 2'd2;
  localparam logic [1:0] ModeOfb = 2'd3;

  localparam logic [1:0] RegKey  = 2'd0;
  localparam logic [1:0] RegIv   = 2'd1;
  localparam logic [1:0] RegMode = 2'd2;
  localparam logic [1:0] RegDec  = 2'd3;

  localparam logic [63:0] IvReset = 64'hA2BB38A6E6DCCDDF;

  typedef logic [7:0] tab_t;

  localparam tab_t TabIp [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab_t TabFp [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab_t TabE [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab_t TabP [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam tab_t TabPc1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam tab_t TabPc2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [15:0] ShiftOne = 16'b1000_0001_0000_0011;

  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = s[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = s[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] s);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = s[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] s);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = s[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] rv, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = rv[32-int'(TabE[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[42-6*i +: 6];
      s[28-4*i +: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
    return p;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/des_round.sv =====
// ----------------------------------------------------------------------------
// DES round engine
// Holds the key schedule halves and the L/R halves, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module des_round (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire         dec_i,
  input  wire [63:0]  key_i,
  input  wire [63:0]  blk_i,
  output logic        done_o,
  output logic [63:0] blk_o
);
  import des_pkg::*;

  logic [27:0] c_q, d_q, c_d, d_d;
  logic [31:0] l_q, r_q;
  logic [3:0]  rnd_q;
  logic        busy_q, dec_q;
  logic [55:0] cd0;
  logic [63:0] ipv;
  logic [27:0] c_rk, d_rk;
  logic        one;

  assign cd0 = perm_pc1(key_i);
  assign ipv = perm_ip(blk_i);
  assign one = ShiftOne[rnd_q];

  // Encryption rotates left before use; decryption uses the unrotated key
  // first and rotates right afterwards, which walks the subkeys backwards.
  always_comb begin
    if (!dec_q) begin
      c_rk = one ? {c_q[26:0], c_q[27]} : {c_q[25:0], c_q[27:26]};
      d_rk = one ? {d_q[26:0], d_q[27]} : {d_q[25:0], d_q[27:26]};
      c_d = c_rk;
      d_d = d_rk;
    end else begin
      c_rk = c_q;
      d_rk = d_q;
      c_d = (ShiftOne[4'd15 - rnd_q]) ? {c_q[0], c_q[27:1]} : {c_q[1:0], c_q[27:2]};
      d_d = (ShiftOne[4'd15 - rnd_q]) ? {d_q[0], d_q[27:1]} : {d_q[1:0], d_q[27:2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == 4'd15) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c_q   <= cd0[55:28];
      d_q   <= cd0[27:0];
      l_q   <= ipv[63:32];
      r_q   <= ipv[31:0];
      dec_q <= dec_i;
    end else if (busy_q) begin
      c_q <= c_d;
      d_q <= d_d;
      l_q <= r_q;
      r_q <= l_q ^ feistel(r_q, perm_pc2({c_rk, d_rk}));
    end
  end

  assign blk_o = perm_fp({r_q, l_q});

  `ASSERT_IMPL(a_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "start while busy")
  `ASSERT_IMPL(a_done_end, clk_i, rst_ni, done_o |-> $past(busy_q) && !busy_q,
               "done without run")
  `ASSERT_IMPL(a_rnd_idle, clk_i, rst_ni, done_o |-> rnd_q == 4'd0, "round count off")
endmodule
`default_nettype wire

// ===== hw/rtl/des_cipher_with_block_modes_top.sv =====
// ----------------------------------------------------------------------------
// DES with ECB, CBC, CFB-8 and OFB modes
// Top level: stream ports, configuration registers and chaining logic.
// ----------------------------------------------------------------------------
// Each word is handled in order: the operands are loaded into the shared round
// unit at the accepting edge, sixteen Feistel rounds follow at one per cycle,
// the round unit flags done with the last round, and the result is then registered. The block
// takes no new word until the result has been taken.
// In CFB-8 only the low byte of the data carries meaning and the result's
// upper bits are zero. Writes to the IV take effect at the next restart.
`default_nettype none
`include "assert_macros.svh"
module des_cipher_with_block_modes_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // data_block
  input  wire         s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_block
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);
  import des_pkg::*;

  logic [63:0] key_q, iv_q, chain_q, data_q, res_q, chain_use, eng_in, eng_out;
  logic [1:0]  mode_q;
  logic        dec_q, busy_q, ovalid_q, start, done, eng_dec;

  assign s_axis_tready = !busy_q && !ovalid_q;
  assign cfg_ready     = 1'b1;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;

  assign chain_use = s_axis_tuser ? iv_q : chain_q;

  always_comb begin
    eng_dec = 1'b0;
    case (mode_q)
      ModeEcb: begin
        eng_in  = s_axis_tdata;
        eng_dec = dec_q;
      end
      ModeCbc: begin
        eng_in  = dec_q ? s_axis_tdata : (s_axis_tdata ^ chain_use);
        eng_dec = dec_q;
      end
      default: eng_in = chain_use;
    endcase
  end

  des_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .dec_i   (eng_dec),
    .key_i   (key_q),
    .blk_i   (eng_in),
    .done_o  (done),
    .blk_o   (eng_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      iv_q     <= IvReset;
      mode_q   <= ModeEcb;
      dec_q    <= 1'b0;
      chain_q  <= IvReset;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          RegKey:  key_q  <= cfg_data_i;
          RegIv:   iv_q   <= cfg_data_i;
          RegMode: mode_q <= cfg_data_i[1:0];
          RegDec:  dec_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start) begin
        busy_q  <= 1'b1;
        chain_q <= chain_use;
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (done) begin
        busy_q   <= 1'b0;
        ovalid_q <= 1'b1;
        case (mode_q)
          ModeCbc: chain_q <= dec_q ? data_q : eng_out;
          ModeCfb: chain_q <= {chain_q[55:0],
                               dec_q ? data_q[7:0] : (eng_out[63:56] ^ data_q[7:0])};
          ModeOfb: chain_q <= eng_out;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) data_q <= s_axis_tdata;
    if (done) begin
      case (mode_q)
        ModeEcb: res_q <= eng_out;
        ModeCbc: res_q <= dec_q ? (eng_out ^ chain_q) : eng_out;
        ModeCfb: res_q <= {56'd0, eng_out[63:56] ^ data_q[7:0]};
        default: res_q <= eng_out ^ data_q;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, busy_q |-> !s_axis_tready, "accept while busy")
  `ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done |-> busy_q && !ovalid_q, "stray done")
  `ASSERT_IMPL(a_one_owner, clk_i, rst_ni, !(busy_q && ovalid_q), "busy with result pending")
endmodule
`default_nettype wire
